### hw/rtl/mrrp_pkg.sv
package mrrp_pkg;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] word;
      logic [6:0]  word_index;
      logic [1:0]  status;
      logic [7:0]  exception_code;
      logic [7:0]  func_code;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CRC_ERROR = 2'd1,
      STATUS_EXCEPTION = 2'd2,
      STATUS_TOO_SHORT = 2'd3
   } status_type;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [6:0]  WORD_LIMIT = 7'd127;

   localparam logic [7:0] FUNC_READ_COILS    = 8'd1;
   localparam logic [7:0] FUNC_READ_DISCRETE = 8'd2;
   localparam logic [7:0] FUNC_READ_HOLDING  = 8'd3;
   localparam logic [7:0] FUNC_READ_INPUT    = 8'd4;

endpackage

### hw/rtl/modbus_rtu_response_parser_top.sv
// Channel  | Dir | Payload   | Handshake
// req_     | in  | req_type  | req_valid / req_stall, one frame byte per request
// rsp_     | out | rsp_type  | rsp_valid / rsp_stall, data word or frame status
//
// One request per cycle, unless stalled: CRC update, field capture and word
// assembly are done in the accepting cycle, results go into a four-entry queue.
// A request gives at most two results (a word and the status on the last byte).
// req_stall rises while fewer than two queue entries are free.
// Synchronous reset clears the frame state and empties the queue.
module modbus_rtu_response_parser_top
   import mrrp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int BP_W    = $clog2(MAX_FRAME_BYTES + 1);
   localparam int Q_DEPTH = 4;
   localparam int QP_W    = $clog2(Q_DEPTH);
   localparam int QC_W    = $clog2(Q_DEPTH + 1);

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   logic [15:0]     crc_ff, crc_in;
   logic [7:0]      dly0_ff, dly0_in, dly1_ff, dly1_in;
   logic [BP_W-1:0] bp_ff, bp_in;
   logic [7:0]      func_ff, func_in;
   logic [7:0]      count_ff, count_in;
   logic [7:0]      half_ff, half_in;
   logic [6:0]      wp_ff, wp_in;

   rsp_type         q_ff [Q_DEPTH];
   logic [QP_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0] cnt_ff, cnt_in;

   logic            accept, pop;
   logic [BP_W-1:0] idx, d;
   logic [8:0]      d9;
   logic            emit, emit_data;
   logic [15:0]     word_val;
   logic [15:0]     rx_crc;
   status_type      st;
   rsp_type         data_item, status_item, item0;
   logic            push0, push1;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = cnt_ff > QC_W'(Q_DEPTH - 2);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = q_ff[rd_ptr_ff];

   assign idx = bp_ff - BP_W'(2);
   assign d   = bp_ff - BP_W'(5);
   assign d9  = 9'(d);

   always_comb begin
      crc_in   = crc_ff;
      dly0_in  = dly0_ff;
      dly1_in  = dly1_ff;
      bp_in    = bp_ff;
      func_in  = func_ff;
      count_in = count_ff;
      half_in  = half_ff;
      wp_in    = wp_ff;
      emit     = 1'b0;
      word_val = '0;

      if (bp_ff >= BP_W'(2)) begin
         crc_in = crc_byte(crc_ff, dly1_ff);
         if (bp_ff < BP_W'(MAX_FRAME_BYTES)) begin
            if (idx == BP_W'(1)) begin
               func_in = dly1_ff;
            end else if (idx == BP_W'(2)) begin
               count_in = dly1_ff;
            end else if (idx >= BP_W'(3)) begin
               if (func_ff == FUNC_READ_HOLDING || func_ff == FUNC_READ_INPUT) begin
                  if (!d[0]) begin
                     half_in = dly1_ff;
                  end else if ((d9 >> 1) < {2'b00, count_ff[7:1]}) begin
                     word_val = {half_ff, dly1_ff};
                     emit     = 1'b1;
                  end
               end else if (func_ff == FUNC_READ_COILS || func_ff == FUNC_READ_DISCRETE) begin
                  if (d9 < {1'b0, count_ff}) begin
                     if (!d[0]) begin
                        half_in = dly1_ff;
                        if (d9 + 9'd1 == {1'b0, count_ff}) begin
                           word_val = {8'h00, dly1_ff};
                           emit     = 1'b1;
                        end
                     end else begin
                        word_val = {dly1_ff, half_ff};
                        emit     = 1'b1;
                     end
                  end
               end
            end
         end
      end

      emit_data = emit && (wp_ff < WORD_LIMIT);
      if (emit_data) begin
         wp_in = wp_ff + 7'd1;
      end

      data_item                = '0;
      data_item.kind           = KIND_DATA;
      data_item.word           = word_val;
      data_item.word_index     = wp_ff;
      data_item.func_code      = func_in;

      rx_crc = {req_data.rx_byte, dly0_ff};
      if (bp_ff < BP_W'(4)) begin
         st = STATUS_TOO_SHORT;
      end else if (rx_crc != crc_in) begin
         st = STATUS_CRC_ERROR;
      end else if (bp_ff == BP_W'(4)) begin
         st = STATUS_EXCEPTION;
      end else begin
         st = STATUS_OK;
      end

      status_item                = '0;
      status_item.kind           = KIND_STATUS;
      status_item.word_index     = wp_in;
      status_item.status         = st;
      status_item.exception_code = (st == STATUS_EXCEPTION) ? count_in : 8'h00;
      status_item.func_code      = func_in;
      status_item.last           = 1'b1;

      item0 = emit_data ? data_item : status_item;
      push0 = emit_data || req_data.last_byte;
      push1 = emit_data && req_data.last_byte;

      if (req_data.last_byte) begin
         crc_in   = CRC_INIT;
         dly0_in  = '0;
         dly1_in  = '0;
         bp_in    = '0;
         func_in  = '0;
         count_in = '0;
         half_in  = '0;
         wp_in    = '0;
      end else begin
         dly1_in = dly0_ff;
         dly0_in = req_data.rx_byte;
         if (bp_ff < BP_W'(MAX_FRAME_BYTES)) begin
            bp_in = bp_ff + BP_W'(1);
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + QP_W'({1'b0, push0} + {1'b0, push1});
         cnt_in    = cnt_ff + QC_W'({1'b0, push0} + {1'b0, push1});
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QP_W'(1);
         cnt_in    = cnt_in - QC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT;
         dly0_ff   <= '0;
         dly1_ff   <= '0;
         bp_ff     <= '0;
         func_ff   <= '0;
         count_ff  <= '0;
         half_ff   <= '0;
         wp_ff     <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (accept) begin
            crc_ff   <= crc_in;
            dly0_ff  <= dly0_in;
            dly1_ff  <= dly1_in;
            bp_ff    <= bp_in;
            func_ff  <= func_in;
            count_ff <= count_in;
            half_ff  <= half_in;
            wp_ff    <= wp_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && push0) begin
         q_ff[wr_ptr_ff] <= item0;
      end
      if (accept && push1) begin
         q_ff[wr_ptr_ff + QP_W'(1)] <= status_item;
      end
   end

endmodule

### tb/tb_modbus_rtu_response_parser_top.sv
module tb_modbus_rtu_response_parser_top
   import mrrp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_CAP      = 256;
   localparam int ITEM_TARGET    = 900;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int TAIL_CYCLES    = 10;

   localparam int TRAILER_NONE = 0;
   localparam int TRAILER_GOOD = 1;
   localparam int TRAILER_BAD  = 2;

   localparam logic [7:0] READ_FUNCS [4] = '{FUNC_READ_COILS, FUNC_READ_DISCRETE,
                                             FUNC_READ_HOLDING, FUNC_READ_INPUT};

   typedef logic [7:0] frame_bytes_type[$];

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type results_due[$];
   int      error_count = 0;
   int      items_sent = 0;
   int      idle_cycles = 0;
   int      stall_left = 0;
   bit      idle_on = 1'b0;

   logic [15:0] crc_acc;
   logic [7:0]  near_byte;
   logic [7:0]  far_byte;
   int unsigned bytes_seen;
   logic [7:0]  func_seen;
   logic [7:0]  count_seen;
   logic [7:0]  held_byte;
   logic [6:0]  words_out;

   modbus_rtu_response_parser_top #(
      .MAX_FRAME_BYTES(FRAME_CAP)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] v;
      v = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic string describe(input rsp_type r);
      return $sformatf("kind=%0d word=%h index=%0d status=%0d exc=%h func=%h last=%0d",
                       r.kind, r.word, r.word_index, r.status, r.exception_code,
                       r.func_code, r.last);
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   task automatic restart_frame();
      crc_acc    = CRC_INIT;
      near_byte  = '0;
      far_byte   = '0;
      bytes_seen = 0;
      func_seen  = '0;
      count_seen = '0;
      held_byte  = '0;
      words_out  = '0;
   endtask

   task automatic parse_byte(input req_type r);
      rsp_type     item;
      logic [15:0] trailer_crc;
      logic [15:0] w;
      bit          emit;
      int unsigned idx;
      int unsigned d;
      w    = '0;
      emit = 1'b0;
      if (bytes_seen >= 2) begin
         crc_acc = crc16_step(crc_acc, far_byte);
         idx = bytes_seen - 2;
         if (bytes_seen < FRAME_CAP) begin
            if (idx == 1) begin
               func_seen = far_byte;
            end else if (idx == 2) begin
               count_seen = far_byte;
            end else if (idx >= 3) begin
               d = idx - 3;
               if (func_seen == FUNC_READ_HOLDING || func_seen == FUNC_READ_INPUT) begin
                  if (d % 2 == 0) begin
                     held_byte = far_byte;
                  end else if ((d >> 1) < (count_seen >> 1)) begin
                     w    = {held_byte, far_byte};
                     emit = 1'b1;
                  end
               end else if (func_seen == FUNC_READ_COILS ||
                            func_seen == FUNC_READ_DISCRETE) begin
                  if (d < count_seen) begin
                     if (d % 2 == 0) begin
                        held_byte = far_byte;
                        if (d + 1 == count_seen) begin
                           w    = {8'h00, far_byte};
                           emit = 1'b1;
                        end
                     end else begin
                        w    = {far_byte, held_byte};
                        emit = 1'b1;
                     end
                  end
               end
            end
            if (emit && words_out < WORD_LIMIT) begin
               item            = '0;
               item.kind       = KIND_DATA;
               item.word       = w;
               item.word_index = words_out;
               item.func_code  = func_seen;
               results_due.push_back(item);
               words_out++;
            end
         end
      end
      if (r.last_byte) begin
         item            = '0;
         item.kind       = KIND_STATUS;
         item.word_index = words_out;
         item.func_code  = func_seen;
         item.last       = 1'b1;
         trailer_crc     = {r.rx_byte, near_byte};
         if (bytes_seen < 4) begin
            item.status = STATUS_TOO_SHORT;
         end else if (trailer_crc != crc_acc) begin
            item.status = STATUS_CRC_ERROR;
         end else if (bytes_seen == 4) begin
            item.status         = STATUS_EXCEPTION;
            item.exception_code = count_seen;
         end else begin
            item.status = STATUS_OK;
         end
         results_due.push_back(item);
         restart_frame();
      end else begin
         far_byte  = near_byte;
         near_byte = r.rx_byte;
         if (bytes_seen < FRAME_CAP) bytes_seen++;
      end
   endtask

   task automatic send_byte(input logic [7:0] value, input logic is_last);
      req_type r;
      int      gap;
      r.rx_byte   = value;
      r.last_byte = is_last;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      parse_byte(r);
      items_sent++;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame(input frame_bytes_type body, input int trailer);
      frame_bytes_type frame;
      logic [15:0]     crc;
      int              k;
      frame = body;
      crc   = CRC_INIT;
      foreach (body[i]) crc = crc16_step(crc, body[i]);
      if (trailer != TRAILER_NONE) begin
         frame.push_back(crc[7:0]);
         frame.push_back(crc[15:8]);
      end
      if (trailer == TRAILER_BAD) begin
         k = $urandom_range(0, frame.size() - 1);
         frame[k] = frame[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_short_frames();
      send_frame('{8'hFF}, TRAILER_NONE);
      send_frame('{8'h00, 8'h80, 8'h7F, 8'hFF}, TRAILER_NONE);
   endtask

   task automatic test_exception_frame();
      send_frame('{8'h11, 8'h83, 8'h02}, TRAILER_GOOD);
   endtask

   task automatic test_register_read();
      send_frame('{8'hFF, FUNC_READ_HOLDING, 8'h02, 8'hFF, 8'h00}, TRAILER_GOOD);
   endtask

   task automatic test_coil_read();
      send_frame('{8'h00, FUNC_READ_COILS, 8'h01, 8'hA5}, TRAILER_GOOD);
   endtask

   task automatic test_overlong_frame();
      frame_bytes_type body;
      body.push_back($urandom_range(0, 255));
      body.push_back(READ_FUNCS[$urandom_range(0, 3)]);
      body.push_back(8'hFF);
      repeat (270) body.push_back($urandom_range(0, 255));
      send_frame(body, TRAILER_GOOD);
   endtask

   task automatic test_random_frames();
      frame_bytes_type body;
      int              pick;
      int              count;
      int              ndata;
      int              trailer;
      int              frames;
      frames = 0;
      while (items_sent < ITEM_TARGET) begin
         if (frames % 8 == 0) idle_on = ($urandom_range(0, 4) != 0);
         frames++;
         body = {};
         body.push_back($urandom_range(0, 255));
         pick    = $urandom_range(0, 99);
         trailer = ($urandom_range(0, 99) < 85) ? TRAILER_GOOD : TRAILER_BAD;
         if (pick < 65) begin
            count = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 12)
                                                : $urandom_range(13, 255);
            ndata = ($urandom_range(0, 3) != 0) ? count : $urandom_range(0, 14);
            if (ndata > 40) ndata = $urandom_range(30, 60);
            body.push_back(READ_FUNCS[$urandom_range(0, 3)]);
            body.push_back(count[7:0]);
            repeat (ndata) body.push_back($urandom_range(0, 255));
         end else if (pick < 75) begin
            body.push_back($urandom_range(128, 255));
            body.push_back($urandom_range(0, 255));
         end else if (pick < 87) begin
            body.push_back($urandom_range(0, 255));
            repeat ($urandom_range(0, 10)) body.push_back($urandom_range(0, 255));
         end else begin
            trailer = TRAILER_NONE;
            repeat ($urandom_range(0, 7)) body.push_back($urandom_range(0, 255));
         end
         send_frame(body, trailer);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            flag_error({"unexpected result: ", describe(rsp_data)});
         end else begin
            due = results_due.pop_front();
            if (rsp_data !== due)
               flag_error({"mismatch: expected ", describe(due),
                           "\n          actual   ", describe(rsp_data)});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_modbus_rtu_response_parser_top: done, errors");
         $finish;
      end
   end

   initial begin
      restart_frame();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_short_frames();
      test_exception_frame();
      test_register_read();
      test_coil_read();
      wait_drained();

      idle_on = 1'b1;
      test_overlong_frame();
      test_random_frames();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (results_due.size() != 0)
         flag_error($sformatf("%0d results never arrived", results_due.size()));
      if (error_count == 0)
         $display("tb_modbus_rtu_response_parser_top: done, clean");
      else
         $display("tb_modbus_rtu_response_parser_top: done, errors");
      $finish;
   end

endmodule
